/* hdl/running_median_two_heaps_macros.svh */
// Assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
// assert that a implies b in the same cycle
`define RM_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b in the next cycle
`define RM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

/* hdl/rmth_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants and types for the running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;
	localparam int CAPACITY_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIELD_BITS      = 16;

	// classified word handed from front to back
	typedef struct packed {
		logic [FIELD_BITS-1:0] sample;
		logic                  drop;
		logic                  to_lower;
	} cmd_t;
endpackage

/* hdl/running_median_two_heaps.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running lower median of a signed sample stream, two heaps in RAM.
// ----------------------------------------------------------------------------
// Input side is a queue: drive sample and push; the word is taken when full
// is low. A two-word queue decouples the classifying front from the heap
// engine behind it.
// Result side is a queue: median and dropped are valid while empty is low;
// pulse pop to take the word. While a result waits, the engine holds and the
// front keeps taking words until its queue is full.
// Each sample costs a take, one heap push (a parent read and a compare per
// level tested, the top included), a tops compare unless the upper heap is
// empty and, on exchange, two sift-downs (a read of each child, a compare
// and a write per level visited), then a read of the lower top to present
// it. Dropped samples go straight from the take to that read. The engine
// works on one word at a time and takes the next one the cycle after the
// previous result is popped. Reset clears counts and queues; heap RAM is
// not cleared.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
	parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [rmth_pkg::FIELD_BITS-1:0] sample,
	output logic                            empty,
	input  logic                            pop,
	output logic [rmth_pkg::FIELD_BITS-1:0] median,
	output logic                            dropped
);
	import rmth_pkg::*;
`include "running_median_two_heaps_macros.svh"

	cmd_t cmd;
	logic cmd_valid, cmd_take;
	logic [FIELD_BITS-1:0] med_raw;

	rmth_front #(.CAPACITY(CAPACITY)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .sample(sample), .full(full),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take));

	rmth_back #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .empty(empty), .pop(pop), .median(med_raw),
		.dropped(dropped));

	assign median = med_raw;

	`RM_ASSERT_IMP(a_take_valid, clk, arst_n, cmd_take, cmd_valid)
	`RM_ASSERT_IMP(a_take_idle, clk, arst_n, cmd_take, empty)
	`RM_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(median))
endmodule

/* hdl/rmth_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rmth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write, and register the read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* hdl/rmth_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_front
// Accepts samples, decides heap and drop, feeds a two-entry queue.
// ----------------------------------------------------------------------------
module rmth_front #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [rmth_pkg::FIELD_BITS-1:0] sample,
	output logic                            full,
	output rmth_pkg::cmd_t                  cmd,
	output logic                            cmd_valid,
	input  logic                            cmd_take
);
	import rmth_pkg::*;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] total_q;
	logic          parity_q;
	cmd_t          fifo_q [2];
	logic [1:0]    cnt_q;
	logic          rd_q, wr_q;
	logic          acc;
	cmd_t          c;

	assign full      = cnt_q == 2'd2;
	assign acc       = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fifo_q[rd_q];

	// classify the incoming word
	always_comb begin
		c.sample   = sample;
		c.drop     = total_q >= CW'(CAPACITY);
		c.to_lower = !parity_q;
	end

	// count accepted samples and queue words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			parity_q <= 1'b0;
			cnt_q    <= '0;
			rd_q     <= 1'b0;
			wr_q     <= 1'b0;
		end else begin
			if (acc && !c.drop) begin
				total_q  <= total_q + 1'b1;
				parity_q <= !parity_q;
			end
			if (acc) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_take};
		end
	end

	// store the queued word
	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= c;
	end
endmodule

/* hdl/rmth_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmth_back
// Carries out heap push, top exchange and sift-downs, with one address shared by both heap RAMs.
// ----------------------------------------------------------------------------
module rmth_back #(
	parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmth_pkg::cmd_t                  cmd,
	input  logic                            cmd_valid,
	output logic                            cmd_take,
	output logic                            empty,
	input  logic                            pop,
	output logic [rmth_pkg::FIELD_BITS-1:0] median,
	output logic                            dropped
);
	import rmth_pkg::*;
	localparam int LD = (CAPACITY + 1) / 2;
	localparam int UD = (CAPACITY / 2 > 1) ? CAPACITY / 2 : 2;
	localparam int LA = (LD > 1) ? $clog2(LD) : 1;
	localparam int UA = $clog2(UD);
	localparam int AW = (LA > UA) ? LA : UA;
	localparam int CNW = AW + 1;
	localparam int SB = SAMPLE_BITS;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_PRD   = 10'b0000000010,
		S_PCMP  = 10'b0000000100,
		S_TRD   = 10'b0000001000,
		S_TCMP  = 10'b0000010000,
		S_RRDL  = 10'b0000100000,
		S_RRDR  = 10'b0001000000,
		S_RCMP  = 10'b0010000000,
		S_RDONE = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t          state_q;
	logic            heap_q;          // 1: lower (max) heap
	logic [CNW-1:0]  lcnt_q, ucnt_q;
	logic [AW-1:0]   idx_q, nxt_q;
	logic [SB-1:0]   v_q, lo_q, hi_q, lv_q;
	logic            pass_q;
	logic            ovalid_q, odrop_q;
	logic [SB-1:0]   omed_q;
	logic            out_rd_q;

	logic            lwe, uwe;
	logic [AW-1:0]   addr;
	logic [SB-1:0]   wd, lrd, urd, rd;
	logic [AW-1:0]   par;
	logic [AW+1:0]   lch_w, rch_w, hcnt_w;
	logic [CNW-1:0]  hcnt;

	assign rd     = heap_q ? lrd : urd;
	assign hcnt   = heap_q ? lcnt_q : ucnt_q;
	assign par    = (idx_q - 1'b1) >> 1;
	// child indexes carry the full range so that bounds checks never wrap
	assign lch_w  = {1'b0, idx_q, 1'b1};
	assign rch_w  = lch_w + 1'b1;
	assign hcnt_w = {1'b0, hcnt};

	rmth_ram #(.WIDTH(SB), .DEPTH(LD)) u_lower (
		.clk(clk), .we(lwe), .addr(addr[LA-1:0]), .wdata(wd), .rdata(lrd));
	rmth_ram #(.WIDTH(SB), .DEPTH(UD)) u_upper (
		.clk(clk), .we(uwe), .addr(addr[UA-1:0]), .wdata(wd), .rdata(urd));

	// signed ordering: true if a belongs above b
	function automatic logic ahead(input logic [SB-1:0] a, input logic [SB-1:0] b,
	                               input logic is_max);
		ahead = is_max ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	logic wen;
	always_comb begin
		wen  = 1'b0;
		addr = idx_q;
		wd   = v_q;
		case (state_q)
			S_PRD:   addr = par;
			S_PCMP: begin
				wen = 1'b1;
				if (idx_q != '0 && ahead(v_q, rd, heap_q)) wd = rd;
			end
			S_TRD:   addr = '0;
			S_RRDL:  addr = lch_w[AW-1:0];
			S_RRDR:  addr = rch_w[AW-1:0];
			S_RDONE: begin
				wen = 1'b1;
				wd  = (nxt_q == idx_q) ? v_q : lv_q;
			end
			S_OUT:   addr = '0;
			default: ;
		endcase
		lwe = wen && heap_q;
		uwe = wen && !heap_q;
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !ovalid_q && !out_rd_q;
	assign empty    = !ovalid_q;
	assign median   = FIELD_BITS'(omed_q);
	assign dropped  = odrop_q;

	// sequence push, exchange test and two sift-downs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lcnt_q   <= '0;
			ucnt_q   <= '0;
			ovalid_q <= 1'b0;
			pass_q   <= 1'b0;
			out_rd_q <= 1'b0;
		end else begin
			// read the lower top during the output state, then present the word
			out_rd_q <= (state_q == S_OUT);
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			if (out_rd_q) begin
				ovalid_q <= 1'b1;
				omed_q   <= (lcnt_q == '0) ? '0 : lrd;
			end
			case (state_q)
				S_IDLE: if (cmd_take) begin
					v_q    <= cmd.sample[SB-1:0];
					heap_q <= cmd.to_lower;
					odrop_q <= cmd.drop;
					if (cmd.drop) state_q <= S_OUT;
					else begin
						idx_q   <= cmd.to_lower ? lcnt_q[AW-1:0] : ucnt_q[AW-1:0];
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PCMP;
				S_PCMP: begin
					if (idx_q != '0 && ahead(v_q, rd, heap_q)) begin
						idx_q   <= par;
						state_q <= S_PRD;
					end else begin
						if (heap_q) lcnt_q <= lcnt_q + 1'b1;
						else        ucnt_q <= ucnt_q + 1'b1;
						heap_q  <= 1'b1;
						state_q <= (ucnt_q != '0 || !heap_q) ? S_TRD : S_OUT;
					end
				end
				S_TRD: begin
					heap_q  <= 1'b0;
					state_q <= S_TCMP;
				end
				S_TCMP: begin
					// both tops read in S_TRD are latched from the registered RAM outputs, then compared
					if (heap_q == 1'b0 && !pass_q) begin
						lo_q   <= lrd;
						hi_q   <= urd;
						pass_q <= 1'b1;
					end
					if (pass_q) begin
						pass_q <= 1'b0;
						if ($signed(lo_q) > $signed(hi_q)) begin
							heap_q  <= 1'b1;
							v_q     <= hi_q;
							idx_q   <= '0;
							state_q <= S_RRDL;
						end else state_q <= S_OUT;
					end
				end
				S_RRDL: begin
					nxt_q <= idx_q;
					lv_q  <= v_q;
					state_q <= S_RRDR;
				end
				S_RRDR: begin
					// left child data arrives now
					if (lch_w < hcnt_w && ahead(rd, v_q, heap_q)) begin
						nxt_q <= lch_w[AW-1:0];
						lv_q  <= rd;
					end
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					if (rch_w < hcnt_w && ahead(rd, lv_q, heap_q)) begin
						nxt_q <= rch_w[AW-1:0];
						lv_q  <= rd;
					end
					state_q <= S_RDONE;
				end
				S_RDONE: begin
					if (nxt_q != idx_q) begin
						idx_q   <= nxt_q;
						state_q <= S_RRDL;
					end else if (heap_q) begin
						heap_q  <= 1'b0;
						v_q     <= lo_q;
						idx_q   <= '0;
						state_q <= S_RRDL;
					end else state_q <= S_OUT;
				end
				S_OUT: begin
					heap_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
